>>> rtl/core/agkf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// agkf_pkg: shared types and constants of the angle/gyro kalman filter
// fixed-point limits, register indexes and reset values
// ---------------------------------------------------------------------------
package agkf_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_PERIOD = 2'd0,
        REG_ANGLE_NOISE   = 2'd1,
        REG_BIAS_NOISE    = 2'd2,
        REG_MEAS_NOISE    = 2'd3
    } cfg_reg_t;

    localparam logic [31:0] SAMPLE_PERIOD_RST = 32'd134218;
    localparam logic [31:0] ANGLE_NOISE_RST   = 32'd16777;
    localparam logic [31:0] BIAS_NOISE_RST    = 32'd83886;
    localparam logic [31:0] MEAS_NOISE_RST    = 32'd8388608;

    localparam logic signed [47:0] ONE_Q32 = 48'sh0001_0000_0000;
    localparam logic signed [63:0] MAX48   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] MIN48   = -64'sh0000_8000_0000_0000;
    localparam logic signed [63:0] MAX32   = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] MIN32   = -64'sh0000_0000_8000_0000;
    localparam logic [61:0]        PROD_CAP = 62'h2000_0000_0000_0000;
    localparam logic [47:0]        GAIN_MAX = 48'h7FFF_FFFF_FFFF;

    function automatic logic signed [63:0] clamp48(input logic signed [63:0] v);
        clamp48 = (v > MAX48) ? MAX48 : ((v < MIN48) ? MIN48 : v);
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        clamp32 = (v > MAX32) ? MAX32 : ((v < MIN32) ? MIN32 : v);
    endfunction

endpackage

>>> rtl/core/angle_gyro_kalman_filter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// angle_gyro_kalman_filter: two-state angle / gyro-bias kalman filter
// fuses an accelerometer angle with a gyro rate, q16.16 in and out
// ---------------------------------------------------------------------------
// One transaction on the s_axis side gives one transaction on the m_axis side.
// Each sample runs through a small sequencer that drives a single 32x32
// magnitude multiplier (products of up to 64x64 bits take four partial-product
// passes) and a restoring divider that makes one quotient bit a cycle. From
// acceptance to result a sample runs ten scaled products (each: operand
// set-up, four partial products, apply), two gain divisions (each: load, 47
// quotient bits, finish) and the load of the output register. The output
// load waits while the previous result is still held in the output register.
// s_axis_tready is low while a sample is in flight; the next sample is taken
// while the previous result may still wait in the output register. Config
// registers are written through cfg_we/cfg_addr/cfg_wdata and must only be
// changed while the filter is idle.
module angle_gyro_kalman_filter
    import agkf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [31:0] measured_angle, [63:32] gyro_rate
    input  logic [63:0]          s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [31:0] fused_angle, [63:32] corrected_rate
    output logic [63:0]          m_axis_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [31:0]          cfg_wdata
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_SETM = 8'b0000_0010,
        ST_MUL  = 8'b0000_0100,
        ST_DIV  = 8'b0000_1000,
        ST_APPL = 8'b0001_0000,
        ST_OUT  = 8'b0010_0000
    } state_t;

    // config
    logic [31:0] dt_reg, qa_reg, qg_reg, rn_reg;

    // filter state
    logic signed [31:0] ang_reg, bias_reg;
    logic signed [47:0] p00_reg, p01_reg, p10_reg, p11_reg;

    // per-sample scratch
    logic signed [31:0] meas_reg, gyro_reg;
    logic signed [32:0] err_reg;
    logic signed [47:0] t0_reg, t1_reg, k0_reg, k1_reg;
    logic signed [49:0] e_reg;

    state_t      state_reg;
    logic [3:0]  op_reg;    // which scaled product / step is in work

    // multiplier unit
    logic [63:0]  ma_reg, mb_reg;
    logic         mneg_reg;
    logic [5:0]   msh_reg;
    logic [1:0]   mph_reg;  // partial-product phase
    logic [127:0] macc_reg;
    logic signed [63:0] mres;

    // divider unit
    logic [46:0]  dnum_reg;
    logic [49:0]  dden_reg;
    logic [49:0]  drem_reg;
    logic [46:0]  dq_reg;
    logic [6:0]   dcnt_reg;
    logic         dneg_reg, dsel_reg, dovf_reg;

    logic         out_v_reg;
    logic [63:0]  out_d_reg;

    // ---------------- operand selection per step ----------------
    // steps: 0 angle predict, 1 p00, 2 p01/p10, 3 p11 propagate,
    // 4 k0*t0, 5 k0*t1, 6 k1*t0, 7 k1*t1, 8 k0*err, 9 k1*err
    logic signed [63:0] opa, opb;
    logic [5:0]         opsh;
    always_comb
    begin
        opa  = '0;
        opb  = '0;
        opsh = 6'd32;
        case (op_reg)
            4'd0:
            begin
                opa = 64'(signed'(gyro_reg)) - 64'(signed'(bias_reg));
                opb = {32'd0, dt_reg};
                opsh = 6'd24;
            end
            4'd1:
            begin
                opa = {24'd0, qa_reg, 8'd0} - 64'(p01_reg) - 64'(p10_reg);
                opb = {32'd0, dt_reg};
                opsh = 6'd24;
            end
            4'd2:
            begin
                opa = -64'(p11_reg);
                opb = {32'd0, dt_reg};
                opsh = 6'd24;
            end
            4'd3:
            begin
                opa = {24'd0, qg_reg, 8'd0};
                opb = {32'd0, dt_reg};
                opsh = 6'd24;
            end
            4'd4:    begin opa = 64'(k0_reg); opb = 64'(t0_reg); end
            4'd5:    begin opa = 64'(k0_reg); opb = 64'(t1_reg); end
            4'd6:    begin opa = 64'(k1_reg); opb = 64'(t0_reg); end
            4'd7:    begin opa = 64'(k1_reg); opb = 64'(t1_reg); end
            4'd8:    begin opa = 64'(k0_reg); opb = 64'(err_reg); end
            4'd9:    begin opa = 64'(k1_reg); opb = 64'(err_reg); end
            default: ;
        endcase
    end

    // one 32x32 partial product per cycle
    logic [31:0] pa, pb;
    logic [63:0] pp;
    always_comb
    begin
        pa = mph_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        pb = mph_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        pp = pa * pb;
    end

    // rounding and cap of the finished product: 2^60 and above reads as 2^61
    logic [127:0] rnd;
    logic [127:0] shd;
    logic [61:0]  mmag;
    always_comb
    begin
        rnd  = macc_reg + (128'd1 << (msh_reg - 6'd1));
        shd  = rnd >> msh_reg;
        mmag = (shd[127:60] != '0) ? PROD_CAP : shd[61:0];
        mres = mneg_reg ? -64'(mmag) : 64'(mmag);
    end

    // divider operand magnitudes
    logic [49:0] div_nmag, div_dmag;
    always_comb
    begin
        div_nmag = dsel_reg ? (p10_reg[47] ? -50'(p10_reg) : 50'(p10_reg))
                            : (p00_reg[47] ? -50'(p00_reg) : 50'(p00_reg));
        div_dmag = e_reg[49] ? 50'(-e_reg) : 50'(e_reg);
    end

    // divider trial subtract, top bit is the borrow
    logic [51:0] dtry;
    always_comb
        dtry = {1'b0, drem_reg, dnum_reg[46]} - {2'b00, dden_reg};

    logic [63:0] ang_new, bias_new;
    logic signed [63:0] e_sum;
    always_comb
    begin
        ang_new  = clamp32(64'(ang_reg) + mres);
        bias_new = clamp32(64'(bias_reg) + mres);
        e_sum    = {24'd0, rn_reg, 8'd0} + 64'(p00_reg);
    end

    // signed q16.32 gain from the quotient magnitude, saturated, zero on zero divisor
    function automatic logic signed [47:0] gain_out(input logic [46:0] q,
                                                    input logic neg,
                                                    input logic ovf,
                                                    input logic zero);
        logic [47:0] m;
        begin
            m = ovf ? GAIN_MAX : {1'b0, q};
            if (zero)
                gain_out = '0;
            else
                gain_out = neg ? -48'(m) : 48'(m);
        end
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_d_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg <= SAMPLE_PERIOD_RST;
            qa_reg <= ANGLE_NOISE_RST;
            qg_reg <= BIAS_NOISE_RST;
            rn_reg <= MEAS_NOISE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_SAMPLE_PERIOD: dt_reg <= cfg_wdata;
                REG_ANGLE_NOISE:   qa_reg <= cfg_wdata;
                REG_BIAS_NOISE:    qg_reg <= cfg_wdata;
                REG_MEAS_NOISE:    rn_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= '0;
            ang_reg   <= '0;
            bias_reg  <= '0;
            p00_reg   <= ONE_Q32;
            p01_reg   <= '0;
            p10_reg   <= '0;
            p11_reg   <= ONE_Q32;
            out_v_reg <= 1'b0;
            mph_reg   <= '0;
            dcnt_reg  <= '0;
            dsel_reg  <= 1'b0;
        end
        else
        begin
            // in ST_OUT a taken result is replaced by the new one below
            if (out_v_reg && m_axis_tready && (state_reg != ST_OUT))
                out_v_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        meas_reg  <= s_axis_tdata[31:0];
                        gyro_reg  <= s_axis_tdata[63:32];
                        op_reg    <= 4'd0;
                        state_reg <= ST_SETM;
                    end
                end
                ST_SETM:
                begin
                    ma_reg   <= opa[63] ? -opa : opa;
                    mb_reg   <= opb[63] ? -opb : opb;
                    mneg_reg <= opa[63] ^ opb[63];
                    msh_reg  <= opsh;
                    macc_reg <= '0;
                    mph_reg  <= 2'd0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    macc_reg <= macc_reg + (128'(pp) <<
                                {{1'b0, mph_reg[1]} + {1'b0, mph_reg[0]}, 5'd0});
                    mph_reg  <= mph_reg + 2'd1;
                    if (mph_reg == 2'd3)
                        state_reg <= ST_APPL;
                end
                ST_APPL:
                begin
                    state_reg <= ST_SETM;
                    op_reg    <= op_reg + 4'd1;
                    case (op_reg)
                        4'd0:
                        begin
                            ang_reg <= ang_new[31:0];
                            err_reg <= 33'(64'(meas_reg) - 64'(signed'(ang_new[31:0])));
                        end
                        4'd1: p00_reg <= 48'(clamp48(64'(p00_reg) + mres));
                        4'd2:
                        begin
                            p01_reg <= 48'(clamp48(64'(p01_reg) + mres));
                            p10_reg <= 48'(clamp48(64'(p10_reg) + mres));
                        end
                        4'd3:
                        begin
                            p11_reg <= 48'(clamp48(64'(p11_reg) + mres));
                            e_reg   <= 50'(e_sum);
                            t0_reg  <= p00_reg;
                            t1_reg  <= p01_reg;
                            dsel_reg <= 1'b0;
                            state_reg <= ST_DIV;
                            dcnt_reg <= '0;
                        end
                        4'd4: p00_reg <= 48'(clamp48(64'(p00_reg) - mres));
                        4'd5: p01_reg <= 48'(clamp48(64'(p01_reg) - mres));
                        4'd6: p10_reg <= 48'(clamp48(64'(p10_reg) - mres));
                        4'd7: p11_reg <= 48'(clamp48(64'(p11_reg) - mres));
                        4'd8: ang_reg <= ang_new[31:0];
                        4'd9:
                        begin
                            bias_reg  <= bias_new[31:0];
                            state_reg <= ST_OUT;
                        end
                        default: ;
                    endcase
                end
                ST_DIV:
                begin
                    // step 0 loads and checks saturation (n >= d * 2^15);
                    // steps 1..47 make the quotient bits below that limit
                    if (dcnt_reg == 7'd0)
                    begin
                        dnum_reg <= {div_nmag[14:0], 32'd0};
                        dneg_reg <= (dsel_reg ? p10_reg[47] : p00_reg[47]) ^ e_reg[49];
                        dovf_reg <= ({15'd0, div_nmag} >= {div_dmag, 15'd0});
                        dden_reg <= div_dmag;
                        drem_reg <= {15'd0, div_nmag[49:15]};
                        dq_reg   <= '0;
                        dcnt_reg <= 7'd1;
                    end
                    else if (dcnt_reg <= 7'd47)
                    begin
                        if (!dtry[51])
                        begin
                            drem_reg <= dtry[49:0];
                            dq_reg   <= {dq_reg[45:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= {drem_reg[48:0], dnum_reg[46]};
                            dq_reg   <= {dq_reg[45:0], 1'b0};
                        end
                        dnum_reg <= {dnum_reg[45:0], 1'b0};
                        dcnt_reg <= dcnt_reg + 7'd1;
                    end
                    else
                    begin
                        dcnt_reg <= '0;
                        if (dsel_reg)
                        begin
                            k1_reg    <= gain_out(dq_reg, dneg_reg, dovf_reg, e_reg == '0);
                            op_reg    <= 4'd4;
                            state_reg <= ST_SETM;
                        end
                        else
                        begin
                            k0_reg   <= gain_out(dq_reg, dneg_reg, dovf_reg, e_reg == '0);
                            dsel_reg <= 1'b1;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (!out_v_reg || m_axis_tready)
                    begin
                        out_v_reg <= 1'b1;
                        out_d_reg <= {32'(clamp32(64'(gyro_reg) - 64'(bias_reg))), ang_reg};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
